// ===== src/pms_pkg.sv =====
package pms_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_SPEED      = 3'd0;
  localparam logic [2:0] REG_MIN_GAP        = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE       = 3'd2;
  localparam logic [2:0] REG_REVERSE_RIGHT  = 3'd3;
  localparam logic [2:0] REG_STRAIGHTEN     = 3'd4;
  localparam logic [2:0] REG_REVERSE_LEFT   = 3'd5;
  localparam logic [2:0] REG_SCAN_PROMPT    = 3'd6;
  localparam logic [2:0] REG_ALIGN_PROMPT   = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register reset values
  localparam logic [15:0] RST_MAX_SPEED     = 16'd10;
  localparam logic [15:0] RST_MIN_GAP       = 16'd6000;
  localparam logic [7:0]  RST_DEBOUNCE      = 8'd3;
  localparam logic [7:0]  RST_REVERSE_RIGHT = 8'd50;
  localparam logic [7:0]  RST_STRAIGHTEN    = 8'd20;
  localparam logic [7:0]  RST_REVERSE_LEFT  = 8'd50;
  localparam logic [7:0]  RST_SCAN_PROMPT   = 8'd1;
  localparam logic [7:0]  RST_ALIGN_PROMPT  = 8'd2;

  // gap sensor read status
  localparam logic [1:0] GAP_STATUS_OK      = 2'd0;
  localparam logic [1:0] GAP_STATUS_NO_DATA = 2'd1;

  // diagnostic event codes
  localparam logic [1:0] EV_SENSOR_INVALID = 2'd0;
  localparam logic [1:0] EV_SPEED_UNSAFE   = 2'd1;
  localparam logic [1:0] EV_GAP_LOST       = 2'd2;

  // phase codes as reported
  localparam logic [2:0] PHASE_CODE_SCAN     = 3'd0;
  localparam logic [2:0] PHASE_CODE_RIGHT    = 3'd1;
  localparam logic [2:0] PHASE_CODE_STRAIGHT = 3'd2;
  localparam logic [2:0] PHASE_CODE_LEFT     = 3'd3;
  localparam logic [2:0] PHASE_CODE_DONE     = 3'd4;

  typedef enum logic [4:0] {
    PH_SCAN     = 5'b00001,
    PH_RIGHT    = 5'b00010,
    PH_STRAIGHT = 5'b00100,
    PH_LEFT     = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        speed_valid;
    logic [15:0] veh_speed;
    logic [1:0]  gap_read_status;
    logic        gap_found;
    logic [15:0] gap_width_mm;
  } pms_in_t;

  typedef struct packed {
    logic [7:0] drv_prompt;
    logic       event_valid;
    logic [1:0] event_code;
    logic [2:0] phase;
  } pms_out_t;

  typedef struct packed {
    logic [15:0] max_speed_kph;
    logic [15:0] min_gap_mm;
    logic [7:0]  debounce_count;
    logic [7:0]  reverse_right_ticks;
    logic [7:0]  straighten_ticks;
    logic [7:0]  reverse_left_ticks;
    logic [7:0]  scan_prompt;
    logic [7:0]  align_prompt;
  } pms_cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] phase_ticks;
    logic [7:0] gap_hits;
  } pms_state_t;

  localparam pms_state_t STATE_RESET = '{phase: PH_SCAN, phase_ticks: 8'd0, gap_hits: 8'd0};

endpackage

// ===== src/park_maneuver_sequencer.sv =====
// a word is held in the input register; its result is registered into out_data when it moves on
// throughput: one word per cycle while not stalled; the state register loops through the step logic once a word
// out_ready may stay low: the input register keeps taking words until both stages are full
// reset (rst, synchronous, active high) empties both stages, returns to scanning
// with zero counts and loads the register defaults
module park_maneuver_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pms_pkg::pms_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pms_pkg::pms_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [pms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pms_pkg::pms_cfg_t   cfg;
  pms_pkg::pms_state_t state;
  pms_pkg::pms_state_t state_next;
  pms_pkg::pms_in_t    in_q;
  pms_pkg::pms_out_t   res;
  logic                in_full;
  logic                move;

  // the held word steps through when the result register is free or draining
  assign move     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || move;

  pms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pms_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .word (in_q),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pms_pkg::STATE_RESET;
    end else if (move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= res;
    end
  end

endmodule

// ===== src/pms_cfg_regs.sv =====
module pms_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output pms_pkg::pms_cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed_kph       <= pms_pkg::RST_MAX_SPEED;
      cfg.min_gap_mm          <= pms_pkg::RST_MIN_GAP;
      cfg.debounce_count      <= pms_pkg::RST_DEBOUNCE;
      cfg.reverse_right_ticks <= pms_pkg::RST_REVERSE_RIGHT;
      cfg.straighten_ticks    <= pms_pkg::RST_STRAIGHTEN;
      cfg.reverse_left_ticks  <= pms_pkg::RST_REVERSE_LEFT;
      cfg.scan_prompt         <= pms_pkg::RST_SCAN_PROMPT;
      cfg.align_prompt        <= pms_pkg::RST_ALIGN_PROMPT;
    end else if (cfg_we) begin
      case (cfg_index)
        pms_pkg::REG_MAX_SPEED:     cfg.max_speed_kph       <= cfg_wdata;
        pms_pkg::REG_MIN_GAP:       cfg.min_gap_mm          <= cfg_wdata;
        pms_pkg::REG_DEBOUNCE:      cfg.debounce_count      <= cfg_wdata[7:0];
        pms_pkg::REG_REVERSE_RIGHT: cfg.reverse_right_ticks <= cfg_wdata[7:0];
        pms_pkg::REG_STRAIGHTEN:    cfg.straighten_ticks    <= cfg_wdata[7:0];
        pms_pkg::REG_REVERSE_LEFT:  cfg.reverse_left_ticks  <= cfg_wdata[7:0];
        pms_pkg::REG_SCAN_PROMPT:   cfg.scan_prompt         <= cfg_wdata[7:0];
        pms_pkg::REG_ALIGN_PROMPT:  cfg.align_prompt        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/pms_step.sv =====
module pms_step (
  input  pms_pkg::pms_cfg_t   cfg,
  input  pms_pkg::pms_state_t cur,
  input  pms_pkg::pms_in_t    word,
  output pms_pkg::pms_state_t nxt,
  output pms_pkg::pms_out_t   res
);

  logic       suitable;
  logic       speed_bad;
  logic [7:0] hits_inc;
  logic [7:0] ticks_inc;
  logic [7:0] limit;
  pms_pkg::phase_t after_phase;

  assign suitable  = word.gap_found && (word.gap_width_mm >= cfg.min_gap_mm);
  assign speed_bad = !word.speed_valid || (word.veh_speed > cfg.max_speed_kph);
  assign hits_inc  = (cur.gap_hits == 8'hFF) ? cur.gap_hits : cur.gap_hits + 8'd1;
  assign ticks_inc = cur.phase_ticks + 8'd1;

  // tick limit and follow-on phase of the timed phases
  always_comb begin
    case (cur.phase)
      pms_pkg::PH_RIGHT: begin
        limit       = cfg.reverse_right_ticks;
        after_phase = pms_pkg::PH_STRAIGHT;
      end
      pms_pkg::PH_STRAIGHT: begin
        limit       = cfg.straighten_ticks;
        after_phase = pms_pkg::PH_LEFT;
      end
      default: begin
        limit       = cfg.reverse_left_ticks;
        after_phase = pms_pkg::PH_DONE;
      end
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    if (speed_bad) begin
      nxt             = pms_pkg::STATE_RESET;
      res.event_valid = 1'b1;
      res.event_code  = pms_pkg::EV_SPEED_UNSAFE;
    end else if (word.gap_read_status != pms_pkg::GAP_STATUS_OK) begin
      if (cur.phase != pms_pkg::PH_SCAN) begin
        nxt = pms_pkg::STATE_RESET;
      end
      if (word.gap_read_status == pms_pkg::GAP_STATUS_NO_DATA) begin
        res.event_valid = 1'b1;
        res.event_code  = pms_pkg::EV_SENSOR_INVALID;
      end
    end else begin
      case (cur.phase)
        pms_pkg::PH_SCAN: begin
          if (suitable) begin
            nxt.gap_hits = hits_inc;
            if (hits_inc >= cfg.debounce_count) begin
              nxt.phase       = pms_pkg::PH_RIGHT;
              nxt.phase_ticks = 8'd0;
            end
          end else begin
            nxt.gap_hits = 8'd0;
          end
        end
        pms_pkg::PH_RIGHT, pms_pkg::PH_STRAIGHT, pms_pkg::PH_LEFT: begin
          if (!suitable) begin
            nxt             = pms_pkg::STATE_RESET;
            res.event_valid = 1'b1;
            res.event_code  = pms_pkg::EV_GAP_LOST;
          end else if (ticks_inc >= limit) begin
            nxt.phase       = after_phase;
            nxt.phase_ticks = 8'd0;
          end else begin
            nxt.phase_ticks = ticks_inc;
          end
        end
        pms_pkg::PH_DONE: ;
        default: nxt = pms_pkg::STATE_RESET;
      endcase
      case (nxt.phase)
        pms_pkg::PH_SCAN: res.drv_prompt = cfg.scan_prompt;
        pms_pkg::PH_RIGHT, pms_pkg::PH_STRAIGHT, pms_pkg::PH_LEFT:
          res.drv_prompt = cfg.align_prompt;
        default: res.drv_prompt = 8'd0;
      endcase
    end
    case (nxt.phase)
      pms_pkg::PH_SCAN:     res.phase = pms_pkg::PHASE_CODE_SCAN;
      pms_pkg::PH_RIGHT:    res.phase = pms_pkg::PHASE_CODE_RIGHT;
      pms_pkg::PH_STRAIGHT: res.phase = pms_pkg::PHASE_CODE_STRAIGHT;
      pms_pkg::PH_LEFT:     res.phase = pms_pkg::PHASE_CODE_LEFT;
      pms_pkg::PH_DONE:     res.phase = pms_pkg::PHASE_CODE_DONE;
      default:              res.phase = pms_pkg::PHASE_CODE_SCAN;
    endcase
  end

endmodule

// ===== src/pms_checker.sv =====
module pms_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input pms_pkg::pms_out_t out_data
);

  // a result waiting for the sink must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word shown right after reset");

  a_no_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |-> out_data.event_code == pms_pkg::EV_SENSOR_INVALID)
    else $error("event code set without an event");

  // a speed fault or a lost gap always lands back in scanning
  a_restart_scan: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_valid &&
    (out_data.event_code == pms_pkg::EV_SPEED_UNSAFE ||
     out_data.event_code == pms_pkg::EV_GAP_LOST)
    |-> out_data.phase == pms_pkg::PHASE_CODE_SCAN)
    else $error("fault event without return to scanning");

  a_speed_prompt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_valid && out_data.event_code == pms_pkg::EV_SPEED_UNSAFE
    |-> out_data.drv_prompt == 8'd0)
    else $error("prompt shown on speed fault");

endmodule

bind park_maneuver_sequencer pms_checker u_pms_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_park_maneuver_sequencer.sv =====
`timescale 1ns / 100ps

module tb_park_maneuver_sequencer;
  import pms_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  // status codes the package leaves unnamed
  localparam logic [1:0] GAP_STATUS_FAIL  = 2'd2;
  localparam logic [1:0] GAP_STATUS_OTHER = 2'd3;

  localparam pms_cfg_t CFG_DEFAULTS = '{
    max_speed_kph: RST_MAX_SPEED, min_gap_mm: RST_MIN_GAP,
    debounce_count: RST_DEBOUNCE, reverse_right_ticks: RST_REVERSE_RIGHT,
    straighten_ticks: RST_STRAIGHTEN, reverse_left_ticks: RST_REVERSE_LEFT,
    scan_prompt: RST_SCAN_PROMPT, align_prompt: RST_ALIGN_PROMPT};

  typedef struct {
    pms_in_t  stim;
    bit       fixed;
    pms_out_t want;
  } dir_row_t;

  typedef struct {
    pms_cfg_t cfg;
    int       words;
    int       noise_pm;
  } run_plan_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  pms_in_t in_data;
  logic out_valid;
  logic out_ready;
  pms_out_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  always #4 clk = ~clk;

  park_maneuver_sequencer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predicted sequencer state and register copy
  pms_cfg_t   park_cfg;
  logic [2:0] park_phase;
  logic [7:0] park_ticks;
  logic [7:0] park_hits;
  logic       park_gap_ok;

  pms_out_t pending_results[$];
  pms_out_t head_result;
  dir_row_t dir_rows[$];
  run_plan_t runs[$];
  int mismatches = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;

  function automatic void park_restart();
    park_phase  = PHASE_CODE_SCAN;
    park_ticks  = 8'd0;
    park_hits   = 8'd0;
    park_gap_ok = 1'b0;
  endfunction

  function automatic pms_out_t advance_park(pms_in_t w);
    pms_out_t r;
    logic suitable;
    logic [7:0] limit;
    logic [2:0] nxt;
    r = '0;
    suitable = w.gap_found && (w.gap_width_mm >= park_cfg.min_gap_mm);
    if (!w.speed_valid || w.veh_speed > park_cfg.max_speed_kph) begin
      park_restart();
      r.event_valid = 1'b1;
      r.event_code = EV_SPEED_UNSAFE;
    end else if (w.gap_read_status != GAP_STATUS_OK) begin
      if (park_phase != PHASE_CODE_SCAN) park_restart();
      if (w.gap_read_status == GAP_STATUS_NO_DATA) begin
        r.event_valid = 1'b1;
        r.event_code = EV_SENSOR_INVALID;
      end
    end else begin
      case (park_phase)
        PHASE_CODE_SCAN: begin
          if (suitable) begin
            if (park_hits != 8'hff) park_hits = park_hits + 8'd1;
            if (park_hits >= park_cfg.debounce_count) begin
              park_gap_ok = 1'b1;
              park_phase = PHASE_CODE_RIGHT;
              park_ticks = 8'd0;
            end
          end else begin
            park_hits = 8'd0;
            park_gap_ok = 1'b0;
          end
        end
        PHASE_CODE_RIGHT, PHASE_CODE_STRAIGHT, PHASE_CODE_LEFT: begin
          if (!suitable) begin
            park_restart();
            r.event_valid = 1'b1;
            r.event_code = EV_GAP_LOST;
          end else begin
            if (park_phase == PHASE_CODE_RIGHT) begin
              limit = park_cfg.reverse_right_ticks;
              nxt = PHASE_CODE_STRAIGHT;
            end else if (park_phase == PHASE_CODE_STRAIGHT) begin
              limit = park_cfg.straighten_ticks;
              nxt = PHASE_CODE_LEFT;
            end else begin
              limit = park_cfg.reverse_left_ticks;
              nxt = PHASE_CODE_DONE;
            end
            // a limit of zero still advances after one tick
            park_ticks = park_ticks + 8'd1;
            if (park_ticks >= limit) begin
              park_phase = nxt;
              park_ticks = 8'd0;
            end
          end
        end
        PHASE_CODE_DONE: ;
        default: park_restart();
      endcase
      if (park_phase == PHASE_CODE_SCAN) r.drv_prompt = park_cfg.scan_prompt;
      else if (park_phase <= PHASE_CODE_LEFT) r.drv_prompt = park_cfg.align_prompt;
      else r.drv_prompt = 8'd0;
    end
    r.phase = park_phase;
    return r;
  endfunction

  function automatic pms_in_t tick_word(logic sv, logic [15:0] spd, logic [1:0] st,
                                        logic found, logic [15:0] width);
    pms_in_t w;
    w.speed_valid = sv;
    w.veh_speed = spd;
    w.gap_read_status = st;
    w.gap_found = found;
    w.gap_width_mm = width;
    return w;
  endfunction

  function automatic pms_out_t result_word(logic [7:0] prompt, logic ev, logic [1:0] code,
                                           logic [2:0] ph);
    pms_out_t r;
    r.drv_prompt = prompt;
    r.event_valid = ev;
    r.event_code = code;
    r.phase = ph;
    return r;
  endfunction

  // mostly clean suitable ticks; the rest breaks one condition or is fully random
  function automatic pms_in_t next_tick(int noise_pm);
    pms_in_t w;
    w = tick_word(1'b1, 16'($urandom_range(park_cfg.max_speed_kph)), GAP_STATUS_OK, 1'b1,
                  16'($urandom_range(65535, park_cfg.min_gap_mm)));
    if ($urandom_range(999) < noise_pm) begin
      case ($urandom_range(3))
        0: begin
          if (park_cfg.max_speed_kph == 16'hffff || $urandom_range(1) == 0)
            w.speed_valid = 1'b0;
          else
            w.veh_speed = 16'($urandom_range(65535, park_cfg.max_speed_kph + 1));
        end
        1: w.gap_read_status = 2'($urandom_range(3, 1));
        2: begin
          if (park_cfg.min_gap_mm == 16'd0 || $urandom_range(1) == 0)
            w.gap_found = 1'b0;
          else
            w.gap_width_mm = 16'($urandom_range(park_cfg.min_gap_mm - 1));
        end
        default: begin
          w.speed_valid = 1'($urandom);
          w.veh_speed = 16'($urandom);
          w.gap_read_status = 2'($urandom);
          w.gap_found = 1'($urandom);
          w.gap_width_mm = 16'($urandom);
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_tick(input pms_in_t w, input bit fixed, input pms_out_t want);
    int gap;
    pms_out_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    predicted = advance_park(w);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // only while idle; junk in the upper byte of the 8-bit registers must be dropped
  task automatic write_cfg(input pms_cfg_t c);
    while (pending_results.size() != 0) @(posedge clk);
    put_reg(REG_MAX_SPEED, c.max_speed_kph);
    put_reg(REG_MIN_GAP, c.min_gap_mm);
    put_reg(REG_DEBOUNCE, {8'($urandom), c.debounce_count});
    put_reg(REG_REVERSE_RIGHT, {8'($urandom), c.reverse_right_ticks});
    put_reg(REG_STRAIGHTEN, {8'($urandom), c.straighten_ticks});
    put_reg(REG_REVERSE_LEFT, {8'($urandom), c.reverse_left_ticks});
    put_reg(REG_SCAN_PROMPT, {8'($urandom), c.scan_prompt});
    put_reg(REG_ALIGN_PROMPT, {8'($urandom), c.align_prompt});
    cfg_we <= 1'b0;
    park_cfg = c;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver stall pattern: bits 8:7 of the cycle counter pick one of four modes
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom);
      2'd2: out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= (rx_cycle % 5) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none pending, expected none got %h", $time, out_data);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("drv_prompt", head_result.drv_prompt, out_data.drv_prompt);
        check_field("event_valid", head_result.event_valid, out_data.event_valid);
        check_field("event_code", head_result.event_code, out_data.event_code);
        check_field("phase", head_result.phase, out_data.phase);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_SPEED;
    cfg_wdata = '0;
    park_cfg = CFG_DEFAULTS;
    park_restart();

    // directed rows under the reset settings
    dir_rows.push_back(dir_row_t'{tick_word(1'b0, 16'd0, GAP_STATUS_OK, 1'b1, 16'hffff), 1'b1,
      result_word(8'd0, 1'b1, EV_SPEED_UNSAFE, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'hffff, GAP_STATUS_OK, 1'b1, 16'hffff), 1'b1,
      result_word(8'd0, 1'b1, EV_SPEED_UNSAFE, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd11, GAP_STATUS_OK, 1'b1, 16'hffff), 1'b1,
      result_word(8'd0, 1'b1, EV_SPEED_UNSAFE, PHASE_CODE_SCAN)});
    // speed and width exactly at their limits
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd10, GAP_STATUS_OK, 1'b1, 16'd6000), 1'b1,
      result_word(RST_SCAN_PROMPT, 1'b0, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd0, GAP_STATUS_OK, 1'b1, 16'd5999), 1'b1,
      result_word(RST_SCAN_PROMPT, 1'b0, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd5, GAP_STATUS_NO_DATA, 1'b0, 16'd0), 1'b1,
      result_word(8'd0, 1'b1, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd5, GAP_STATUS_FAIL, 1'b1, 16'hffff), 1'b1,
      result_word(8'd0, 1'b0, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd5, GAP_STATUS_OTHER, 1'b1, 16'hffff), 1'b1,
      result_word(8'd0, 1'b0, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    repeat (3) dir_rows.push_back(dir_row_t'{
      tick_word(1'b1, 16'd3, GAP_STATUS_OK, 1'b1, 16'hffff), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd3, GAP_STATUS_OK, 1'b0, 16'hffff), 1'b1,
      result_word(RST_SCAN_PROMPT, 1'b1, EV_GAP_LOST, PHASE_CODE_SCAN)});
    repeat (3) dir_rows.push_back(dir_row_t'{
      tick_word(1'b1, 16'd7, GAP_STATUS_OK, 1'b1, 16'd8000), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd7, GAP_STATUS_NO_DATA, 1'b1, 16'd8000), 1'b1,
      result_word(8'd0, 1'b1, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    repeat (3) dir_rows.push_back(dir_row_t'{
      tick_word(1'b1, 16'd1, GAP_STATUS_OK, 1'b1, 16'd6001), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd1, GAP_STATUS_FAIL, 1'b1, 16'd6001), 1'b1,
      result_word(8'd0, 1'b0, EV_SENSOR_INVALID, PHASE_CODE_SCAN)});
    repeat (3) dir_rows.push_back(dir_row_t'{
      tick_word(1'b1, 16'd9, GAP_STATUS_OK, 1'b1, 16'd7000), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{tick_word(1'b0, 16'd9, GAP_STATUS_OK, 1'b1, 16'd7000), 1'b1,
      result_word(8'd0, 1'b1, EV_SPEED_UNSAFE, PHASE_CODE_SCAN)});
    dir_rows.push_back(dir_row_t'{tick_word(1'b1, 16'd2, GAP_STATUS_OK, 1'b1, 16'd0), 1'b0, '0});

    // random runs, each under its own register setting
    runs.push_back(run_plan_t'{'{max_speed_kph: 16'd10, min_gap_mm: 16'd6000,
      debounce_count: 8'd2, reverse_right_ticks: 8'd3, straighten_ticks: 8'd2,
      reverse_left_ticks: 8'd4, scan_prompt: 8'd1, align_prompt: 8'd2}, 90, 80});
    runs.push_back(run_plan_t'{'{max_speed_kph: 16'd0, min_gap_mm: 16'd0,
      debounce_count: 8'd0, reverse_right_ticks: 8'd0, straighten_ticks: 8'd0,
      reverse_left_ticks: 8'd0, scan_prompt: 8'd0, align_prompt: 8'd255}, 70, 150});
    runs.push_back(run_plan_t'{'{max_speed_kph: 16'hffff, min_gap_mm: 16'hffff,
      debounce_count: 8'd255, reverse_right_ticks: 8'd1, straighten_ticks: 8'd1,
      reverse_left_ticks: 8'd1, scan_prompt: 8'd255, align_prompt: 8'd0}, 270, 2});
    runs.push_back(run_plan_t'{'{max_speed_kph: 16'd100, min_gap_mm: 16'd3000,
      debounce_count: 8'd1, reverse_right_ticks: 8'd255, straighten_ticks: 8'd1,
      reverse_left_ticks: 8'd2, scan_prompt: 8'($urandom), align_prompt: 8'($urandom)},
      260, 1});
    runs.push_back(run_plan_t'{CFG_DEFAULTS, 50, 40});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_tick(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);
    in_valid <= 1'b0;
    burst_left = 0;

    foreach (runs[i]) begin
      write_cfg(runs[i].cfg);
      repeat (runs[i].words) send_tick(next_tick(runs[i].noise_pm), 1'b0, '0);
      in_valid <= 1'b0;
      burst_left = 0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
